FILE: design/cair_pkg.sv
// Shared types, constants and saturating fixed-point helpers for the
// chaotic attractor integrator step pipeline.
// Depends on nothing; every other design file refers to this package.
package cair_pkg;

  localparam int WORD_BITS      = 32;
  localparam int FRAC_BITS      = 16;
  localparam int STEP_BITS      = 17;
  localparam int CFG_INDEX_BITS = 3;
  localparam int AXES           = 3;
  localparam int DIVISOR        = 6;

  typedef logic signed [WORD_BITS-1:0]   word_t;
  typedef logic signed [2*WORD_BITS-1:0] dword_t;
  typedef logic [WORD_BITS-1:0]          uword_t;
  typedef logic [2*WORD_BITS-1:0]        udword_t;
  typedef word_t [AXES-1:0]              vec_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Reciprocal of the final divisor, scaled by two to the word width.
  localparam logic [WORD_BITS:0] DIV_FULL = {1'b1, {WORD_BITS{1'b0}}} / DIVISOR;
  localparam uword_t DIV_MUL = DIV_FULL[WORD_BITS-1:0];
  localparam uword_t DIV_U   = uword_t'(DIVISOR);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_STEP_SIZE    = 3'd0,
    REG_METHOD       = 3'd1,
    REG_SYSTEM       = 3'd2,
    REG_COEFF_FIRST  = 3'd3,
    REG_COEFF_SECOND = 3'd4,
    REG_COEFF_THIRD  = 3'd5
  } cfg_reg_t;

  localparam logic METHOD_EULER   = 1'b0;
  localparam logic METHOD_RK4     = 1'b1;
  localparam logic SYSTEM_LORENZ  = 1'b0;
  localparam logic SYSTEM_ROSSLER = 1'b1;

  localparam logic [STEP_BITS-1:0] STEP_RESET = 17'd655;
  localparam word_t COEFF_FIRST_RESET  = word_t'(1835008);
  localparam word_t COEFF_SECOND_RESET = word_t'(655360);
  localparam word_t COEFF_THIRD_RESET  = word_t'(174763);

  typedef struct packed {
    word_t v;
    logic  ov;
  } sat_t;

  typedef struct packed {
    logic [STEP_BITS-1:0] step_size;
    logic                 method_select;
    logic                 system_select;
    word_t                coeff_first;
    word_t                coeff_second;
    word_t                coeff_third;
  } cfg_t;

  // Context that travels down the pipeline with each point.
  typedef struct packed {
    vec_t p;
    vec_t k1;
    vec_t k2;
    vec_t k3;
    vec_t eu;
    logic ov;
    logic ov_eu;
  } ctx_t;

  // Saturation flags of one advance unit.
  typedef struct packed {
    logic mul;
    logic half;
    logic full;
  } adv_ov_t;

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
  } in_t;

  typedef struct packed {
    word_t next_x;
    word_t next_y;
    word_t next_z;
    logic  overflow_flag;
  } out_t;

  function automatic sat_t sat_add(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    sat_t r;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    r.ov = s[WORD_BITS] ^ s[WORD_BITS-1];
    r.v  = r.ov ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_BITS-1:0]);
    return r;
  endfunction

  function automatic sat_t sat_sub(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    sat_t r;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    r.ov = s[WORD_BITS] ^ s[WORD_BITS-1];
    r.v  = r.ov ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_BITS-1:0]);
    return r;
  endfunction

  // Exact signed product, to be registered before it is scaled.
  function automatic dword_t mul_full(input word_t a, input word_t b);
    return dword_t'(a) * dword_t'(b);
  endfunction

  // Shift a product down by the fraction bits (floor) and saturate.
  function automatic sat_t mul_fit(input dword_t p);
    dword_t sh;
    logic [WORD_BITS:0] hi;
    sat_t r;
    sh = p >>> FRAC_BITS;
    hi = sh[2*WORD_BITS-1:WORD_BITS-1];
    r.ov = !((&hi) || (~|hi));
    r.v  = r.ov ? (p[2*WORD_BITS-1] ? WORD_MIN : WORD_MAX) : word_t'(sh[WORD_BITS-1:0]);
    return r;
  endfunction

  // Halve, truncating toward zero.
  function automatic word_t halve(input word_t d);
    word_t r;
    r = (d + word_t'(d[WORD_BITS-1])) >>> 1;
    return r;
  endfunction

  function automatic word_t step_word(input logic [STEP_BITS-1:0] h);
    return word_t'({{(WORD_BITS-STEP_BITS){1'b0}}, h});
  endfunction

endpackage

FILE: design/cair_deriv.sv
// Three-stage derivative unit: evaluates the Lorenz or Rossler flow at a point.
// Depends on cair_pkg.
module cair_deriv (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cair_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  cair_pkg::ctx_t    in_ctx,
  input  cair_pkg::vec_t    in_pt,
  output logic              out_valid,
  output cair_pkg::ctx_t    out_ctx,
  output cair_pkg::vec_t    out_k
);

  cair_pkg::sat_t  a1, a2, r1, r2;
  cair_pkg::word_t op_a [4];
  cair_pkg::word_t op_b [4];
  logic            ov1;
  cair_pkg::ctx_t  s1_ctx_next;

  logic            s1_valid;
  cair_pkg::ctx_t  s1_ctx;
  cair_pkg::vec_t  s1_pt;
  cair_pkg::word_t s1_r1;
  cair_pkg::word_t s1_a [4];
  cair_pkg::word_t s1_b [4];

  logic             s2_valid;
  cair_pkg::ctx_t   s2_ctx;
  cair_pkg::vec_t   s2_pt;
  cair_pkg::word_t  s2_r1;
  cair_pkg::dword_t s2_prod [4];

  cair_pkg::sat_t f [4];
  cair_pkg::sat_t e0, e1, e2;
  cair_pkg::vec_t k_next;
  logic           ov3;
  cair_pkg::ctx_t out_ctx_next;

  // Stage one: differences that feed the products, operand selection.
  always_comb begin
    a1 = cair_pkg::sat_sub(in_pt[1], in_pt[0]);
    a2 = cair_pkg::sat_sub(cfg.coeff_first, in_pt[2]);
    r1 = cair_pkg::sat_sub('0, in_pt[1]);
    r2 = cair_pkg::sat_sub(in_pt[0], cfg.coeff_third);
    if (cfg.system_select == cair_pkg::SYSTEM_LORENZ) begin
      op_a[0] = cfg.coeff_second; op_b[0] = a1.v;
      op_a[1] = in_pt[0];         op_b[1] = a2.v;
      op_a[2] = in_pt[0];         op_b[2] = in_pt[1];
      op_a[3] = cfg.coeff_third;  op_b[3] = in_pt[2];
      ov1 = a1.ov | a2.ov;
    end else begin
      op_a[0] = cfg.coeff_first;  op_b[0] = in_pt[1];
      op_a[1] = in_pt[2];         op_b[1] = r2.v;
      op_a[2] = '0;               op_b[2] = '0;
      op_a[3] = '0;               op_b[3] = '0;
      ov1 = r1.ov | r2.ov;
    end
    s1_ctx_next    = in_ctx;
    s1_ctx_next.ov = in_ctx.ov | ov1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_ctx <= s1_ctx_next;
      s1_pt  <= in_pt;
      s1_r1  <= r1.v;
      for (int i = 0; i < 4; i++) begin
        s1_a[i] <= op_a[i];
        s1_b[i] <= op_b[i];
      end
    end
  end

  // Stage two: four full-width products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_ctx <= s1_ctx;
      s2_pt  <= s1_pt;
      s2_r1  <= s1_r1;
      for (int i = 0; i < 4; i++) begin
        s2_prod[i] <= cair_pkg::mul_full(s1_a[i], s1_b[i]);
      end
    end
  end

  // Stage three: scale the products and form the three derivatives.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      f[i] = cair_pkg::mul_fit(s2_prod[i]);
    end
    if (cfg.system_select == cair_pkg::SYSTEM_LORENZ) begin
      e0 = f[0];
      e1 = cair_pkg::sat_sub(f[1].v, s2_pt[1]);
      e2 = cair_pkg::sat_sub(f[2].v, f[3].v);
      ov3 = f[0].ov | f[1].ov | f[2].ov | f[3].ov | e1.ov | e2.ov;
    end else begin
      e0 = cair_pkg::sat_sub(s2_r1, s2_pt[2]);
      e1 = cair_pkg::sat_add(s2_pt[0], f[0].v);
      e2 = cair_pkg::sat_add(cfg.coeff_second, f[1].v);
      ov3 = f[0].ov | f[1].ov | e0.ov | e1.ov | e2.ov;
    end
    k_next[0] = e0.v;
    k_next[1] = e1.v;
    k_next[2] = e2.v;
    out_ctx_next    = s2_ctx;
    out_ctx_next.ov = s2_ctx.ov | ov3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
    if (en) begin
      out_ctx <= out_ctx_next;
      out_k   <= k_next;
    end
  end

endmodule

FILE: design/cair_adv.sv
// Two-stage advance unit: forms p + k*h and p + (k*h)/2 for each axis.
// Depends on cair_pkg.
module cair_adv (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cair_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  cair_pkg::ctx_t    in_ctx,
  input  cair_pkg::vec_t    in_k,
  output logic              out_valid,
  output cair_pkg::ctx_t    out_ctx,
  output cair_pkg::vec_t    out_half,
  output cair_pkg::vec_t    out_full,
  output cair_pkg::adv_ov_t out_ov
);

  logic             s1_valid;
  cair_pkg::ctx_t   s1_ctx;
  cair_pkg::dword_t s1_prod [cair_pkg::AXES];

  cair_pkg::sat_t    f  [cair_pkg::AXES];
  cair_pkg::sat_t    hs [cair_pkg::AXES];
  cair_pkg::sat_t    fs [cair_pkg::AXES];
  cair_pkg::adv_ov_t ov_next;

  // Stage one: k times the step.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_ctx <= in_ctx;
      for (int i = 0; i < cair_pkg::AXES; i++) begin
        s1_prod[i] <= cair_pkg::mul_full(in_k[i], cair_pkg::step_word(cfg.step_size));
      end
    end
  end

  // Stage two: scale, then add the full and the halved offset to the point.
  always_comb begin
    ov_next = '0;
    for (int i = 0; i < cair_pkg::AXES; i++) begin
      f[i]  = cair_pkg::mul_fit(s1_prod[i]);
      hs[i] = cair_pkg::sat_add(s1_ctx.p[i], cair_pkg::halve(f[i].v));
      fs[i] = cair_pkg::sat_add(s1_ctx.p[i], f[i].v);
      ov_next.mul  = ov_next.mul | f[i].ov;
      ov_next.half = ov_next.half | hs[i].ov;
      ov_next.full = ov_next.full | fs[i].ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
    if (en) begin
      out_ctx <= s1_ctx;
      out_ov  <= ov_next;
      for (int i = 0; i < cair_pkg::AXES; i++) begin
        out_half[i] <= hs[i].v;
        out_full[i] <= fs[i].v;
      end
    end
  end

endmodule

FILE: design/cair_comb.sv
// Eight-stage Runge-Kutta combiner: weighted slope sum, times h, divided by
// six, added to the point, or the Euler point; the output register is last.
// Depends on cair_pkg.
module cair_comb (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cair_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  cair_pkg::ctx_t in_ctx,
  input  cair_pkg::vec_t in_k4,
  output logic           out_valid,
  output cair_pkg::out_t out_data
);

  localparam int W = cair_pkg::WORD_BITS;
  localparam int N = cair_pkg::AXES;

  logic           v1, v2, v3, v4, v5, v6, v7;
  cair_pkg::ctx_t c1, c2, c3, c4, c5, c6, c7;
  cair_pkg::vec_t k4_1, k4_2;
  cair_pkg::vec_t t1, sum2, sum3;
  cair_pkg::dword_t prod4 [N];
  cair_pkg::uword_t mag5 [N];
  cair_pkg::uword_t mag6 [N];
  cair_pkg::udword_t recip6 [N];
  logic [N-1:0] neg5, neg6;
  cair_pkg::vec_t d7;

  cair_pkg::sat_t t_s [N];
  cair_pkg::sat_t u_s [N];
  cair_pkg::sat_t w_s [N];
  cair_pkg::sat_t s_s [N];
  cair_pkg::sat_t f_s [N];
  cair_pkg::sat_t r_s [N];
  cair_pkg::uword_t q0 [N];
  cair_pkg::uword_t rem [N];
  cair_pkg::uword_t q [N];
  logic ov1, ov2, ov3, ov5, ov8;
  cair_pkg::vec_t rk_pt;
  cair_pkg::ctx_t c1_next, c2_next, c3_next, c5_next;
  cair_pkg::out_t out_next;

  // Stage logic of every step, one axis at a time.
  always_comb begin
    ov1 = 1'b0; ov2 = 1'b0; ov3 = 1'b0; ov5 = 1'b0; ov8 = 1'b0;
    for (int i = 0; i < N; i++) begin
      t_s[i] = cair_pkg::sat_add(in_ctx.k2[i], in_ctx.k3[i]);
      u_s[i] = cair_pkg::sat_add(t1[i], t1[i]);
      w_s[i] = cair_pkg::sat_add(c1.k1[i], u_s[i].v);
      s_s[i] = cair_pkg::sat_add(sum2[i], k4_2[i]);
      f_s[i] = cair_pkg::mul_fit(prod4[i]);
      q0[i]  = recip6[i][2*W-1:W];
      rem[i] = mag6[i] - ((q0[i] << 2) + (q0[i] << 1));
      q[i]   = (rem[i] >= cair_pkg::DIV_U) ? q0[i] + 1'b1 : q0[i];
      r_s[i] = cair_pkg::sat_add(c7.p[i], d7[i]);
      rk_pt[i] = r_s[i].v;
      ov1 = ov1 | t_s[i].ov;
      ov2 = ov2 | u_s[i].ov | w_s[i].ov;
      ov3 = ov3 | s_s[i].ov;
      ov5 = ov5 | f_s[i].ov;
      ov8 = ov8 | r_s[i].ov;
    end
    // Contexts with the flags of their stage folded in.
    c1_next    = in_ctx;
    c1_next.ov = in_ctx.ov | ov1;
    c2_next    = c1;
    c2_next.ov = c1.ov | ov2;
    c3_next    = c2;
    c3_next.ov = c2.ov | ov3;
    c5_next    = c4;
    c5_next.ov = c4.ov | ov5;
    // Choose the Runge-Kutta or the Euler result.
    if (cfg.method_select == cair_pkg::METHOD_RK4) begin
      out_next.next_x        = rk_pt[0];
      out_next.next_y        = rk_pt[1];
      out_next.next_z        = rk_pt[2];
      out_next.overflow_flag = c7.ov | ov8;
    end else begin
      out_next.next_x        = c7.eu[0];
      out_next.next_y        = c7.eu[1];
      out_next.next_z        = c7.eu[2];
      out_next.overflow_flag = c7.ov_eu;
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6; out_valid <= v7;
    end
  end

  // Payload of the stages.
  always_ff @(posedge clk) begin
    if (en) begin
      // Sum of the middle slopes.
      c1 <= c1_next;
      k4_1 <= in_k4;
      // Add the doubled middle sum to the first slope.
      c2 <= c2_next;
      k4_2 <= k4_1;
      // Add the last slope.
      c3 <= c3_next;
      // Times the step.
      c4 <= c3;
      // Scale, split sign and magnitude.
      c5 <= c5_next;
      // Reciprocal multiply for the division.
      c6 <= c5;
      c7 <= c6;
      for (int i = 0; i < N; i++) begin
        t1[i]     <= t_s[i].v;
        sum2[i]   <= w_s[i].v;
        sum3[i]   <= s_s[i].v;
        prod4[i]  <= cair_pkg::mul_full(sum3[i], cair_pkg::step_word(cfg.step_size));
        neg5[i]   <= f_s[i].v[W-1];
        mag5[i]   <= f_s[i].v[W-1] ? cair_pkg::uword_t'(-f_s[i].v)
                                   : cair_pkg::uword_t'(f_s[i].v);
        neg6[i]   <= neg5[i];
        mag6[i]   <= mag5[i];
        recip6[i] <= cair_pkg::udword_t'(mag5[i]) * cair_pkg::udword_t'(cair_pkg::DIV_MUL);
        // Correct the quotient once and restore its sign.
        d7[i]     <= neg6[i] ? -cair_pkg::word_t'(q[i]) : cair_pkg::word_t'(q[i]);
      end
      // Output register.
      out_data <= out_next;
    end
  end

endmodule

FILE: design/chaotic_attractor_integrator_step.sv
// Top level of the chaotic attractor integrator step: configuration
// registers and the derivative, advance and combiner pipeline.
// Depends on cair_pkg, cair_deriv, cair_adv and cair_comb.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data  (pos_x, pos_y, pos_z)
//   out      output     out_valid / out_ready  out_data (next_x..z, overflow_flag)
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// One point enters per cycle unless the output stalls, and passes 26 register
// stages: four three-stage derivative units, three two-stage advance units
// and the eight-stage combiner, whose last stage is the output register.
// Reset (rst, synchronous) clears all valid bits and loads the register defaults.
// While a result waits on out_ready the whole pipeline holds; nothing is lost.
module chaotic_attractor_integrator_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cair_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cair_pkg::out_t                      out_data,
  input  logic                                cfg_write,
  input  logic [cair_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  cair_pkg::word_t                     cfg_data
);

  cair_pkg::cfg_t cfg;
  logic           en;

  cair_pkg::ctx_t ctx0, d1_ctx, ctx1, a1_ctx, ctx2, d2_ctx, ctx3, a2_ctx, ctx4;
  cair_pkg::ctx_t d3_ctx, ctx5, a3_ctx, ctx6, d4_ctx;
  cair_pkg::vec_t d1_k, d2_k, d3_k, d4_k;
  cair_pkg::vec_t a1_half, a1_full, a2_half, a2_full, a3_half, a3_full;
  cair_pkg::adv_ov_t a1_ov, a2_ov, a3_ov;
  logic d1_v, a1_v, d2_v, a2_v, d3_v, a3_v, d4_v;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{step_size:     cair_pkg::STEP_RESET,
               method_select: cair_pkg::METHOD_RK4,
               system_select: cair_pkg::SYSTEM_LORENZ,
               coeff_first:   cair_pkg::COEFF_FIRST_RESET,
               coeff_second:  cair_pkg::COEFF_SECOND_RESET,
               coeff_third:   cair_pkg::COEFF_THIRD_RESET};
    end else if (cfg_write) begin
      case (cair_pkg::cfg_reg_t'(cfg_index))
        cair_pkg::REG_STEP_SIZE:    cfg.step_size     <= cfg_data[cair_pkg::STEP_BITS-1:0];
        cair_pkg::REG_METHOD:       cfg.method_select <= cfg_data[0];
        cair_pkg::REG_SYSTEM:       cfg.system_select <= cfg_data[0];
        cair_pkg::REG_COEFF_FIRST:  cfg.coeff_first   <= cfg_data;
        cair_pkg::REG_COEFF_SECOND: cfg.coeff_second  <= cfg_data;
        cair_pkg::REG_COEFF_THIRD:  cfg.coeff_third   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Context of an incoming point.
  always_comb begin
    ctx0      = '0;
    ctx0.p[0] = in_data.pos_x;
    ctx0.p[1] = in_data.pos_y;
    ctx0.p[2] = in_data.pos_z;
  end

  // First slope, then the Euler point and the first half step.
  cair_deriv u_d1 (
    .clk, .rst, .en, .cfg,
    .in_valid(in_valid && in_ready), .in_ctx(ctx0), .in_pt(ctx0.p),
    .out_valid(d1_v), .out_ctx(d1_ctx), .out_k(d1_k)
  );

  always_comb begin
    ctx1    = d1_ctx;
    ctx1.k1 = d1_k;
  end

  cair_adv u_a1 (
    .clk, .rst, .en, .cfg,
    .in_valid(d1_v), .in_ctx(ctx1), .in_k(ctx1.k1),
    .out_valid(a1_v), .out_ctx(a1_ctx), .out_half(a1_half), .out_full(a1_full),
    .out_ov(a1_ov)
  );

  always_comb begin
    ctx2       = a1_ctx;
    ctx2.eu    = a1_full;
    ctx2.ov_eu = a1_ctx.ov | a1_ov.mul | a1_ov.full;
    ctx2.ov    = a1_ctx.ov | a1_ov.mul | a1_ov.half;
  end

  // Second slope and the second half step.
  cair_deriv u_d2 (
    .clk, .rst, .en, .cfg,
    .in_valid(a1_v), .in_ctx(ctx2), .in_pt(a1_half),
    .out_valid(d2_v), .out_ctx(d2_ctx), .out_k(d2_k)
  );

  always_comb begin
    ctx3    = d2_ctx;
    ctx3.k2 = d2_k;
  end

  cair_adv u_a2 (
    .clk, .rst, .en, .cfg,
    .in_valid(d2_v), .in_ctx(ctx3), .in_k(ctx3.k2),
    .out_valid(a2_v), .out_ctx(a2_ctx), .out_half(a2_half), .out_full(a2_full),
    .out_ov(a2_ov)
  );

  always_comb begin
    ctx4    = a2_ctx;
    ctx4.ov = a2_ctx.ov | a2_ov.mul | a2_ov.half;
  end

  // Third slope and the full step.
  cair_deriv u_d3 (
    .clk, .rst, .en, .cfg,
    .in_valid(a2_v), .in_ctx(ctx4), .in_pt(a2_half),
    .out_valid(d3_v), .out_ctx(d3_ctx), .out_k(d3_k)
  );

  always_comb begin
    ctx5    = d3_ctx;
    ctx5.k3 = d3_k;
  end

  cair_adv u_a3 (
    .clk, .rst, .en, .cfg,
    .in_valid(d3_v), .in_ctx(ctx5), .in_k(ctx5.k3),
    .out_valid(a3_v), .out_ctx(a3_ctx), .out_half(a3_half), .out_full(a3_full),
    .out_ov(a3_ov)
  );

  always_comb begin
    ctx6    = a3_ctx;
    ctx6.ov = a3_ctx.ov | a3_ov.mul | a3_ov.full;
  end

  // Fourth slope and the weighted combination.
  cair_deriv u_d4 (
    .clk, .rst, .en, .cfg,
    .in_valid(a3_v), .in_ctx(ctx6), .in_pt(a3_full),
    .out_valid(d4_v), .out_ctx(d4_ctx), .out_k(d4_k)
  );

  cair_comb u_comb (
    .clk, .rst, .en, .cfg,
    .in_valid(d4_v), .in_ctx(d4_ctx), .in_k4(d4_k),
    .out_valid, .out_data
  );

endmodule

FILE: design/cair_checker.sv
// Port-level checker for the integrator step, attached by the bind below.
// Depends on cair_pkg and chaotic_attractor_integrator_step.
module cair_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input cair_pkg::out_t out_data
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result changed");

  // The input is taken exactly when the output register can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind chaotic_attractor_integrator_step cair_checker u_cair_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

FILE: tb/cair_step_checker.sv
// Checker for the chaotic attractor integrator step: watches the input, output
// and configuration ports, predicts each result and compares it on arrival.
// Depends on cair_pkg for the port types and register indexes.
module cair_step_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  cair_pkg::in_t                       in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  cair_pkg::out_t                      out_data,
  input  logic                                cfg_write,
  input  logic [cair_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  cair_pkg::word_t                     cfg_data,
  output int                                  fail_count,
  output int                                  outstanding,
  output int                                  results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import cair_pkg::*;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } point_t;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // Shadow copy of the configuration registers.
  logic [STEP_BITS-1:0] h_reg;
  logic                 method_reg;
  logic                 system_reg;
  longint               c1;
  longint               c2;
  longint               c3;

  out_t expected_points[$];

  // Saturating arithmetic on the word range; any clamp raises the flag.
  function automatic longint clamp(input longint v, inout bit ov);
    if (v > SAT_HI) begin
      ov = 1'b1;
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      ov = 1'b1;
      return SAT_LO;
    end
    return v;
  endfunction

  function automatic longint qadd(input longint a, input longint b, inout bit ov);
    return clamp(a + b, ov);
  endfunction

  function automatic longint qsub(input longint a, input longint b, inout bit ov);
    return clamp(a - b, ov);
  endfunction

  // Product floored by the fraction bits, then saturated.
  function automatic longint qmul(input longint a, input longint b, inout bit ov);
    longint p;
    p = a * b;
    return clamp(p >>> FRAC_BITS, ov);
  endfunction

  // Time derivative of the selected flow at one point.
  function automatic point_t slope(input point_t p, inout bit ov);
    point_t d;
    if (system_reg == SYSTEM_LORENZ) begin
      d.x = qmul(c2, qsub(p.y, p.x, ov), ov);
      d.y = qsub(qmul(p.x, qsub(c1, p.z, ov), ov), p.y, ov);
      d.z = qsub(qmul(p.x, p.y, ov), qmul(c3, p.z, ov), ov);
    end else begin
      d.x = qsub(qsub(0, p.y, ov), p.z, ov);
      d.y = qadd(p.x, qmul(c1, p.y, ov), ov);
      d.z = qadd(c2, qmul(p.z, qsub(p.x, c3, ov), ov), ov);
    end
    return d;
  endfunction

  // Moves p along k by h, or by h/2 with the offset truncated toward zero.
  function automatic point_t shift_point(input point_t p, input point_t k, input longint h,
                                         input bit half, inout bit ov);
    longint dx;
    longint dy;
    longint dz;
    point_t r;
    dx = qmul(k.x, h, ov);
    dy = qmul(k.y, h, ov);
    dz = qmul(k.z, h, ov);
    if (half) begin
      dx = dx / 2;
      dy = dy / 2;
      dz = dz / 2;
    end
    r.x = qadd(p.x, dx, ov);
    r.y = qadd(p.y, dy, ov);
    r.z = qadd(p.z, dz, ov);
    return r;
  endfunction

  function automatic longint weighted_sum(input longint k1, input longint k2, input longint k3,
                                          input longint k4, input longint h, inout bit ov);
    longint t;
    longint s;
    t = qadd(k2, k3, ov);
    s = qadd(qadd(k1, qadd(t, t, ov), ov), k4, ov);
    return qmul(s, h, ov) / 6;
  endfunction

  // Next point after one Euler or fourth-order Runge-Kutta step.
  function automatic out_t integrate(input in_t pt);
    bit     ov;
    longint h;
    point_t p;
    point_t r;
    point_t k1;
    point_t k2;
    point_t k3;
    point_t k4;
    out_t   o;
    ov = 1'b0;
    h = longint'(h_reg);
    p.x = longint'(pt.pos_x);
    p.y = longint'(pt.pos_y);
    p.z = longint'(pt.pos_z);
    k1 = slope(p, ov);
    if (method_reg == METHOD_EULER) begin
      r = shift_point(p, k1, h, 1'b0, ov);
    end else begin
      k2 = slope(shift_point(p, k1, h, 1'b1, ov), ov);
      k3 = slope(shift_point(p, k2, h, 1'b1, ov), ov);
      k4 = slope(shift_point(p, k3, h, 1'b0, ov), ov);
      r.x = qadd(p.x, weighted_sum(k1.x, k2.x, k3.x, k4.x, h, ov), ov);
      r.y = qadd(p.y, weighted_sum(k1.y, k2.y, k3.y, k4.y, h, ov), ov);
      r.z = qadd(p.z, weighted_sum(k1.z, k2.z, k3.z, k4.z, h, ov), ov);
    end
    o.next_x = word_t'(r.x);
    o.next_y = word_t'(r.y);
    o.next_z = word_t'(r.z);
    o.overflow_flag = ov;
    return o;
  endfunction

  task automatic report(input string field, input longint want, input longint got);
    $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
    fail_count++;
  endtask

  // Track configuration, predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      h_reg      <= STEP_RESET;
      method_reg <= METHOD_RK4;
      system_reg <= SYSTEM_LORENZ;
      c1         <= longint'(COEFF_FIRST_RESET);
      c2         <= longint'(COEFF_SECOND_RESET);
      c3         <= longint'(COEFF_THIRD_RESET);
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_STEP_SIZE:    h_reg      <= cfg_data[STEP_BITS-1:0];
          REG_METHOD:       method_reg <= cfg_data[0];
          REG_SYSTEM:       system_reg <= cfg_data[0];
          REG_COEFF_FIRST:  c1         <= longint'(cfg_data);
          REG_COEFF_SECOND: c2         <= longint'(cfg_data);
          REG_COEFF_THIRD:  c3         <= longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_points.push_back(integrate(in_data));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_points.size() == 0) begin
          $display("%0t ns: result with nothing expected, got %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          if (want.next_x != out_data.next_x) report("next_x", want.next_x, out_data.next_x);
          if (want.next_y != out_data.next_y) report("next_y", want.next_y, out_data.next_y);
          if (want.next_z != out_data.next_z) report("next_z", want.next_z, out_data.next_z);
          if (want.overflow_flag != out_data.overflow_flag) begin
            report("overflow_flag", want.overflow_flag, out_data.overflow_flag);
          end
        end
      end
    end
    outstanding = expected_points.size();
  end

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

endmodule

FILE: tb/tb_chaotic_attractor_integrator_step.sv
// Testbench top for the chaotic attractor integrator step: drives points and
// register settings, stalls the output, and reports the verdict.
// Depends on cair_pkg, cair_step_checker and the block itself.
module tb_chaotic_attractor_integrator_step;
  timeunit 1ns;
  timeprecision 1ps;
  import cair_pkg::*;

  localparam int PHASES       = 12;
  localparam int PHASE_POINTS = 130;
  localparam int SETTLE       = 40;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  in_t                       in_data;
  logic                      out_valid;
  logic                      out_ready;
  out_t                      out_data;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  word_t                     cfg_data;
  int                        fail_count;
  int                        outstanding;
  int                        results_seen;

  int points_sent;
  int burst_left;
  int hold_cycles;

  chaotic_attractor_integrator_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cair_step_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding), .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mix of full-range words, saturation extremes and attractor-sized values.
  function automatic word_t pick_coord();
    case ($urandom_range(0, 7))
      0, 1: return word_t'($urandom);
      2:    return WORD_MAX;
      3:    return WORD_MIN;
      4:    return word_t'($urandom_range(0, 2000)) - word_t'(1000);
      default: return word_t'($urandom_range(0, 100 << FRAC_BITS)) - word_t'(50 << FRAC_BITS);
    endcase
  endfunction

  function automatic in_t make_point(input word_t x, input word_t y, input word_t z);
    in_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    return p;
  endfunction

  // One input transfer, then either stay in the burst or leave a gap.
  task automatic send_point(input in_t p);
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Let every expected result arrive and the pipeline empty out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Caller lowers cfg_write once the batch of writes is done.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input word_t val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_coeffs(input word_t a, input word_t b, input word_t c);
    write_reg(REG_COEFF_FIRST, a);
    write_reg(REG_COEFF_SECOND, b);
    write_reg(REG_COEFF_THIRD, c);
  endtask

  // Register settings for each phase, extremes first, random ones last.
  task automatic configure(input int ph);
    case (ph)
      0: begin
        write_reg(REG_UNUSED, word_t'($urandom));
        write_reg(REG_METHOD, word_t'(METHOD_EULER));
      end
      1: begin
        write_reg(REG_METHOD, word_t'(METHOD_RK4));
        write_reg(REG_STEP_SIZE, word_t'(1));
      end
      2: begin
        write_reg(REG_SYSTEM, word_t'(SYSTEM_ROSSLER));
        write_reg(REG_STEP_SIZE, word_t'(655));
        set_coeffs(word_t'(13107), word_t'(13107), word_t'(373555));
      end
      3: begin
        write_reg(REG_METHOD, word_t'(METHOD_EULER));
        write_reg(REG_STEP_SIZE, word_t'(65536));
      end
      4: begin
        write_reg(REG_SYSTEM, word_t'(SYSTEM_LORENZ));
        write_reg(REG_METHOD, word_t'(METHOD_RK4));
        write_reg(REG_STEP_SIZE, 32'hffff_ffff);
        set_coeffs(COEFF_FIRST_RESET, COEFF_SECOND_RESET, COEFF_THIRD_RESET);
      end
      5: begin
        write_reg(REG_SYSTEM, word_t'(SYSTEM_ROSSLER));
        write_reg(REG_STEP_SIZE, word_t'(0));
      end
      6: begin
        write_reg(REG_SYSTEM, word_t'(SYSTEM_LORENZ));
        write_reg(REG_STEP_SIZE, word_t'(3277));
        set_coeffs(WORD_MAX, WORD_MAX, WORD_MAX);
      end
      7: begin
        write_reg(REG_SYSTEM, word_t'(SYSTEM_ROSSLER));
        set_coeffs(WORD_MIN, WORD_MIN, WORD_MIN);
      end
      default: begin
        write_reg(REG_STEP_SIZE, word_t'($urandom_range(0, 131071)));
        write_reg(REG_METHOD, word_t'($urandom_range(0, 1)));
        write_reg(REG_SYSTEM, word_t'($urandom_range(0, 1)));
        set_coeffs(pick_coord(), pick_coord(), pick_coord());
      end
    endcase
    cfg_write <= 1'b0;
  endtask

  // Receiver: switches between stall patterns, and honors a long hold when asked.
  initial begin
    int mode;
    int left;
    out_ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(16, 128);
      end
      left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    points_sent = 0;
    burst_left  = 0;
    hold_cycles = 0;
    rst         = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed points under the reset settings.
    send_point(make_point('0, '0, '0));
    send_point(make_point(WORD_MAX, WORD_MAX, WORD_MAX));
    send_point(make_point(WORD_MIN, WORD_MIN, WORD_MIN));
    send_point(make_point(WORD_MAX, WORD_MIN, WORD_MAX));
    send_point(make_point(WORD_MIN, WORD_MAX, '0));
    send_point(make_point(word_t'(1), word_t'(-1), word_t'(1)));
    send_point(make_point(word_t'(65536), word_t'(65536), word_t'(65536)));
    send_point(make_point(word_t'(-65536), word_t'(131072), word_t'(1638400)));
    send_point(make_point(word_t'(-1), word_t'(-1), word_t'(-1)));
    send_point(make_point(word_t'(655360), word_t'(-655360), word_t'(1835008)));
    send_point(make_point(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_ffff));
    send_point(make_point(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_0000));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      configure(ph);
      // One phase starts with the output held off so the pipeline backs up.
      if (ph == 2) hold_cycles = 400;
      for (int i = 0; i < PHASE_POINTS; i++) begin
        send_point(make_point(pick_coord(), pick_coord(), pick_coord()));
      end
    end

    drain();
    $display("Ran %0d points through %0d register settings and checked %0d results.",
             points_sent, PHASES + 1, results_seen);
    $display("Both flows, Euler and fourth-order steps, zero and full-range step sizes.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
